>>> src/euler_xyz_point_rotation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Euler XYZ point rotation block
// Shared property templates; each use expands to one labelled assertion.
// ----------------------------------------------------------------------------
`ifndef EULER_XYZ_POINT_ROTATION_TOP_MACROS_SVH
`define EULER_XYZ_POINT_ROTATION_TOP_MACROS_SVH

// Overlapping implication, checked while out of reset
`define EXR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define EXR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/exr_pkg.sv
// ----------------------------------------------------------------------------
// exr_pkg
// Shared types and constants of the Euler XYZ point rotation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package exr_pkg;

  // Default geometry
  localparam int unsigned ANGLE_BITS_DEF = 12;
  localparam int unsigned COORD_BITS_DEF = 24;

  // Extra bits carried by the rotation datapath over the coordinate width
  localparam int unsigned VEC_GROWTH = 4;

  // Quarter-wave table entry (0..32768) and signed Q1.15 trig value
  localparam int unsigned SINE_W = 16;
  localparam int unsigned TRIG_W = 17;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X = 3'd0,
    REG_ANGLE_Y = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_PIVOT_X = 3'd3,
    REG_PIVOT_Y = 3'd4,
    REG_PIVOT_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Angle register write, decoded from the config port
  typedef struct packed {
    logic  we;
    axis_e axis;
  } angle_wr_t;

  // Sine and cosine of one axis, signed Q1.15
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

endpackage

>>> src/euler_xyz_point_rotation_top.sv
// ----------------------------------------------------------------------------
// euler_xyz_point_rotation_top
// Rotates a Q8.16 vertex about a pivot: X, then Y, then Z axis.
//
// Channel   Dir  Signals                                  Beat taken when
// command   in   start, in_x_i, in_y_i, in_z_i            start && !busy
// result    out  out_valid_o, out_x_o, out_y_o, out_z_o   out_valid_o (one cycle)
// config    in   cfg_we_i, cfg_idx_i, cfg_wdata_i         cfg_we_i
//
// One vertex per cycle while busy is low; each result is registered after the
// pivot subtract, each rotation's multiply and round/sum, and the pivot add.
// After reset busy stays high while the sine table is swept into RAM and the
// axes looked up; angle writes in that window can prolong it.
// Each angle write holds busy high for the cycle after it.
// Results are strobed for one cycle only; the receiver has no stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "euler_xyz_point_rotation_top_macros.svh"

module euler_xyz_point_rotation_top
  import exr_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_x_i,
  input  logic signed [COORD_BITS-1:0] in_y_i,
  input  logic signed [COORD_BITS-1:0] in_z_i,
  // result
  output logic                         out_valid_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic signed [COORD_BITS-1:0] out_z_o,
  // config
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_wdata_i
);

  localparam int unsigned VW      = COORD_BITS + VEC_GROWTH;
  localparam int unsigned LATENCY = 8;

  localparam logic signed [VW:0] SAT_MAX =
    {{(VW-COORD_BITS+2){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [VW:0] SAT_MIN =
    {{(VW-COORD_BITS+2){1'b1}}, {(COORD_BITS-1){1'b0}}};

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [VW:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > SAT_MAX) begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (v < SAT_MIN) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  logic signed [COORD_BITS-1:0] pivot_x_q, pivot_y_q, pivot_z_q;
  angle_wr_t                    ang_wr;
  trig_t [NUM_AXES-1:0]         trig;
  logic                         trig_ready;
  logic                         accept;

  logic                         s0_vld_q;
  logic signed [VW-1:0]         dx_q, dy_q, dz_q;
  logic signed [VW-1:0]         dx_d, dy_d, dz_d;

  logic                         xr_vld, yr_vld, zr_vld;
  logic signed [VW-1:0]         xr_a, xr_b, xr_c;
  logic signed [VW-1:0]         yr_a, yr_b, yr_c;
  logic signed [VW-1:0]         zr_a, zr_b, zr_c;
  logic signed [VW:0]           sum_x, sum_y, sum_z;

  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q, out_z_q;

  // Config decode: angles go to the trig unit, pivots stay here
  always_comb begin
    ang_wr = '{we: 1'b0, axis: AXIS_X};
    case (cfg_idx_i)
      REG_ANGLE_X: ang_wr = '{we: cfg_we_i, axis: AXIS_X};
      REG_ANGLE_Y: ang_wr = '{we: cfg_we_i, axis: AXIS_Y};
      REG_ANGLE_Z: ang_wr = '{we: cfg_we_i, axis: AXIS_Z};
      default:     ang_wr = '{we: 1'b0, axis: AXIS_X};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= '0;
      pivot_y_q <= '0;
      pivot_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PIVOT_X: pivot_x_q <= cfg_wdata_i;
        REG_PIVOT_Y: pivot_y_q <= cfg_wdata_i;
        REG_PIVOT_Z: pivot_z_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  exr_trig #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ang_wr_i  (ang_wr),
    .ang_val_i (cfg_wdata_i[ANGLE_BITS-1:0]),
    .trig_o    (trig),
    .ready_o   (trig_ready)
  );

  assign busy   = !trig_ready;
  assign accept = start && trig_ready;

  // Stage 0: vertex relative to the pivot
  assign dx_d = VW'(in_x_i) - VW'(pivot_x_q);
  assign dy_d = VW'(in_y_i) - VW'(pivot_y_q);
  assign dz_d = VW'(in_z_i) - VW'(pivot_z_q);

  // About X: (y, z) turn, x rides along
  exr_rot #(.VEC_W (VW)) u_rot_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig[AXIS_X]),
    .vld_i  (s0_vld_q),
    .a_i    (dy_q),
    .b_i    (dz_q),
    .c_i    (dx_q),
    .vld_o  (xr_vld),
    .a_o    (xr_a),
    .b_o    (xr_b),
    .c_o    (xr_c)
  );

  // About Y: (z, x) turn, y rides along
  exr_rot #(.VEC_W (VW)) u_rot_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig[AXIS_Y]),
    .vld_i  (xr_vld),
    .a_i    (xr_b),
    .b_i    (xr_c),
    .c_i    (xr_a),
    .vld_o  (yr_vld),
    .a_o    (yr_a),
    .b_o    (yr_b),
    .c_o    (yr_c)
  );

  // About Z: (x, y) turn, z rides along
  exr_rot #(.VEC_W (VW)) u_rot_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig[AXIS_Z]),
    .vld_i  (yr_vld),
    .a_i    (yr_b),
    .b_i    (yr_c),
    .c_i    (yr_a),
    .vld_o  (zr_vld),
    .a_o    (zr_a),
    .b_o    (zr_b),
    .c_o    (zr_c)
  );

  // Last stage: pivot back in, saturate
  assign sum_x = (VW+1)'(zr_a) + (VW+1)'(pivot_x_q);
  assign sum_y = (VW+1)'(zr_b) + (VW+1)'(pivot_y_q);
  assign sum_z = (VW+1)'(zr_c) + (VW+1)'(pivot_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_vld_q    <= accept;
      out_valid_q <= zr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dz_q    <= dz_d;
    out_x_q <= sat_coord(sum_x);
    out_y_q <= sat_coord(sum_y);
    out_z_q <= sat_coord(sum_z);
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

  `EXR_ASSERT_IMP(a_beat_delivered, clk_i, rst_ni, start && !busy, ##LATENCY out_valid_o,
    "accepted beat produced no result")
  `EXR_ASSERT_IMP(a_result_has_source, clk_i, rst_ni, out_valid_o,
    $past(start && !busy, LATENCY), "result strobe without an accepted beat")
  `EXR_ASSERT_NEXT(a_angle_write_busy, clk_i, rst_ni, ang_wr.we, busy,
    "beat taken while a new angle was still being looked up")

endmodule

>>> src/exr_ram.sv
// ----------------------------------------------------------------------------
// exr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/exr_trig.sv
// ----------------------------------------------------------------------------
// exr_trig
// Angle registers and sine/cosine lookup from a quarter-wave table in RAM.
// After reset the table is swept into the RAM, then all three axes are
// looked up once; later each angle write looks up its own axis. Ready drops
// for the cycle in which a looked-up pair is still on its way to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "euler_xyz_point_rotation_top_macros.svh"

module exr_trig
  import exr_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  angle_wr_t                   ang_wr_i,
  input  logic [ANGLE_BITS-1:0]       ang_val_i,
  output trig_t [NUM_AXES-1:0]        trig_o,
  output logic                        ready_o
);

  localparam int unsigned RW      = ANGLE_BITS - 2;
  localparam int unsigned QUARTER = 1 << RW;
  localparam int unsigned DEPTH   = QUARTER + 1;
  localparam int unsigned AW      = $clog2(DEPTH);

  localparam int unsigned SINE_ONE     = 1 << 15;
  localparam int unsigned SERIES_TERMS = 12;
  localparam int unsigned T_SHIFT      = 62 - ANGLE_BITS;
  localparam int unsigned Q60_ROUND    = 44;
  localparam int unsigned Q60_TO_Q15   = 45;
  localparam logic [63:0] HALF_PI_Q60  = 64'h1921FB54442D1846;
  // (2n)(2n+1) for the Taylor terms
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam trig_t TRIG_RESET = '{sin_v: '0, cos_v: TRIG_W'(SINE_ONE)};

  typedef logic [SINE_W-1:0] sine_rom_t [DEPTH];

  typedef enum logic [1:0] {
    ST_FILL,
    ST_REFRESH,
    ST_RUN
  } state_e;

  // (a*b) >> 60, elaboration only
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, lo, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    lo  = al * bl;
    mid = ah * bl + al * bh + (lo >> 32);
    return ah * bh * 64'd16 + (mid >> 28);
  endfunction

  // Quarter-wave sine table, Q1.15 magnitude, built by Taylor series
  function automatic sine_rom_t build_rom();
    sine_rom_t   rom;
    logic [63:0] t, t2, term, sum, e;
    for (int k = 0; k < DEPTH; k++) begin
      t    = mul_q60(HALF_PI_Q60, 64'(k) << T_SHIFT);
      t2   = mul_q60(t, t);
      term = t;
      sum  = t;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        term = mul_q60(term, t2) / SERIES_DIV[n-1];
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      e = (sum + (64'd1 << Q60_ROUND)) >> Q60_TO_Q15;
      rom[k] = (e > 64'(SINE_ONE)) ? SINE_W'(SINE_ONE) : e[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  state_e                  state_q, state_d;
  logic [AW-1:0]           fill_cnt_q, fill_cnt_d;
  axis_e                   ref_axis_q, ref_axis_d;
  logic [ANGLE_BITS-1:0]   angle_q [NUM_AXES];
  trig_t [NUM_AXES-1:0]    trig_q, trig_d;
  logic                    lkp_vld_q;
  axis_e                   lkp_axis_q;
  logic [1:0]              lkp_quad_q;

  logic                    req_vld;
  axis_e                   req_axis;
  logic [ANGLE_BITS-1:0]   req_angle;
  logic                    ram_we;
  logic [AW-1:0]           raddr_a, raddr_b;
  logic [SINE_W-1:0]       rdata_a, rdata_b;
  logic [SINE_W-1:0]       sin_mag, cos_mag;

  // Lookup request: an angle write wins over the refresh sweep
  always_comb begin
    req_vld   = 1'b0;
    req_axis  = AXIS_X;
    req_angle = ang_val_i;
    if (ang_wr_i.we) begin
      req_vld  = 1'b1;
      req_axis = ang_wr_i.axis;
    end else if (state_q == ST_REFRESH) begin
      req_vld   = 1'b1;
      req_axis  = ref_axis_q;
      req_angle = angle_q[ref_axis_q];
    end
  end

  // Residue within the quadrant and its mirror
  assign raddr_a = AW'(req_angle[RW-1:0]);
  assign raddr_b = AW'(QUARTER) - raddr_a;
  assign ram_we  = (state_q == ST_FILL);

  exr_ram #(
    .WIDTH (SINE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (fill_cnt_q),
    .wdata_i   (SINE_ROM[fill_cnt_q]),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Quadrant symmetry: odd quadrants mirror, cos is sin a quarter on
  assign sin_mag = lkp_quad_q[0] ? rdata_b : rdata_a;
  assign cos_mag = lkp_quad_q[0] ? rdata_a : rdata_b;

  always_comb begin
    trig_d = trig_q;
    if (lkp_vld_q) begin
      trig_d[lkp_axis_q].sin_v = lkp_quad_q[1] ? -TRIG_W'(sin_mag) : TRIG_W'(sin_mag);
      trig_d[lkp_axis_q].cos_v = (lkp_quad_q[1] ^ lkp_quad_q[0]) ?
                                 -TRIG_W'(cos_mag) : TRIG_W'(cos_mag);
    end
  end

  // Sequencer: table sweep, one lookup per axis, then run
  always_comb begin
    state_d    = state_q;
    fill_cnt_d = fill_cnt_q;
    ref_axis_d = ref_axis_q;
    case (state_q)
      ST_FILL: begin
        if (fill_cnt_q == AW'(QUARTER)) begin
          state_d    = ST_REFRESH;
          ref_axis_d = AXIS_X;
        end else begin
          fill_cnt_d = fill_cnt_q + AW'(1);
        end
      end
      ST_REFRESH: begin
        // an angle write takes the lookup port this cycle
        if (!ang_wr_i.we) begin
          case (ref_axis_q)
            AXIS_X:  ref_axis_d = AXIS_Y;
            AXIS_Y:  ref_axis_d = AXIS_Z;
            default: state_d    = ST_RUN;
          endcase
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_cnt_q <= '0;
      ref_axis_q <= AXIS_X;
      lkp_vld_q  <= 1'b0;
      lkp_axis_q <= AXIS_X;
      lkp_quad_q <= '0;
      trig_q     <= {NUM_AXES{TRIG_RESET}};
      for (int i = 0; i < NUM_AXES; i++) begin
        angle_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      fill_cnt_q <= fill_cnt_d;
      ref_axis_q <= ref_axis_d;
      lkp_vld_q  <= req_vld;
      lkp_axis_q <= req_axis;
      lkp_quad_q <= req_angle[ANGLE_BITS-1 -: 2];
      trig_q     <= trig_d;
      if (ang_wr_i.we) begin
        angle_q[ang_wr_i.axis] <= ang_val_i;
      end
    end
  end

  // Not ready while a new sine/cosine pair has yet to reach trig_q
  assign trig_o  = trig_q;
  assign ready_o = (state_q == ST_RUN) && !lkp_vld_q;

  `EXR_ASSERT_NEXT(a_run_holds, clk_i, rst_ni, state_q == ST_RUN, state_q == ST_RUN,
    "trig unit left run state")
  `EXR_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, state_q == ST_FILL,
    fill_cnt_q <= AW'(QUARTER), "table sweep ran past the last entry")
  `EXR_ASSERT_IMP(a_ready_no_sweep, clk_i, rst_ni, ready_o, !ram_we,
    "table written while ready")

endmodule

>>> src/exr_rot.sv
// ----------------------------------------------------------------------------
// exr_rot
// One plane rotation, two pipeline stages: four registered products, then
// rounding and the sum/difference.
//   a' = P(a,cos) - P(b,sin),  b' = P(b,cos) + P(a,sin),  c' = c
// P rounds to nearest, ties towards plus infinity, and drops 15 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "euler_xyz_point_rotation_top_macros.svh"

module exr_rot
  import exr_pkg::*;
#(
  parameter int unsigned VEC_W = COORD_BITS_DEF + VEC_GROWTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  trig_t                   trig_i,
  input  logic                    vld_i,
  input  logic signed [VEC_W-1:0] a_i,
  input  logic signed [VEC_W-1:0] b_i,
  input  logic signed [VEC_W-1:0] c_i,
  output logic                    vld_o,
  output logic signed [VEC_W-1:0] a_o,
  output logic signed [VEC_W-1:0] b_o,
  output logic signed [VEC_W-1:0] c_o
);

  localparam int unsigned PW         = VEC_W + TRIG_W;
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned ROUND_HALF = 1 << (FRAC_BITS - 1);

  logic signed [TRIG_W-1:0] sin_v, cos_v;

  logic                    m_vld_q;
  logic signed [PW-1:0]    pac_q, pbs_q, pbc_q, pas_q;
  logic signed [PW-1:0]    pac_d, pbs_d, pbc_d, pas_d;
  logic signed [VEC_W-1:0] m_c_q;

  logic signed [PW-1:0]    rac, rbs, rbc, ras;
  logic signed [VEC_W:0]   sum_a, sum_b;

  logic                    s_vld_q;
  logic signed [VEC_W-1:0] a_q, b_q, c_q;

  assign sin_v = $signed(trig_i.sin_v);
  assign cos_v = $signed(trig_i.cos_v);

  // Multiply stage
  assign pac_d = a_i * cos_v;
  assign pbs_d = b_i * sin_v;
  assign pbc_d = b_i * cos_v;
  assign pas_d = a_i * sin_v;

  // Round stage: add half an LSB, keep bits above the fraction
  assign rac   = pac_q + PW'(ROUND_HALF);
  assign rbs   = pbs_q + PW'(ROUND_HALF);
  assign rbc   = pbc_q + PW'(ROUND_HALF);
  assign ras   = pas_q + PW'(ROUND_HALF);
  assign sum_a = (VEC_W+1)'(rac[FRAC_BITS +: VEC_W]) - (VEC_W+1)'(rbs[FRAC_BITS +: VEC_W]);
  assign sum_b = (VEC_W+1)'(rbc[FRAC_BITS +: VEC_W]) + (VEC_W+1)'(ras[FRAC_BITS +: VEC_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      m_vld_q <= vld_i;
      s_vld_q <= m_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pac_q <= pac_d;
    pbs_q <= pbs_d;
    pbc_q <= pbc_d;
    pas_q <= pas_d;
    m_c_q <= c_i;
    a_q   <= sum_a[VEC_W-1:0];
    b_q   <= sum_b[VEC_W-1:0];
    c_q   <= m_c_q;
  end

  assign vld_o = s_vld_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign c_o   = c_q;

  `EXR_ASSERT_IMP(a_rot_latency, clk_i, rst_ni, vld_i, ##2 vld_o,
    "rotation beat lost between stages")
  `EXR_ASSERT_NEXT(a_rot_mid_stage, clk_i, rst_ni, vld_i, m_vld_q,
    "rotation beat missing from the product stage")
  `EXR_ASSERT_IMP(a_rot_has_source, clk_i, rst_ni, vld_o, $past(vld_i, 2),
    "rotation output without an input beat")

endmodule
